// ===== sv/block_bitmap_and_inode_stack_allocator_top_defines.svh =====
// Assertion macros shared by the allocator RTL.
// Both macros expect signals named clk and rst_n in the enclosing scope.
`ifndef BLOCK_BITMAP_AND_INODE_STACK_ALLOCATOR_TOP_DEFINES_SVH
`define BLOCK_BITMAP_AND_INODE_STACK_ALLOCATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBIA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbia: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BBIA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbia: next-cycle check failed");

`endif

// ===== sv/bbia_pkg.sv =====
package bbia_pkg;

    localparam int NUM_BLOCKS_DEF = 1024;
    localparam int NUM_INODES_DEF = 128;

    localparam int WORD_W     = 32;
    localparam int WORD_SHIFT = 5;

    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FN_ALLOC_BLOCK = 3'd0;
    localparam logic [FUNC_W-1:0] FN_FREE_BLOCK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_MARK_BLOCK  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_ALLOC_INODE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_FREE_INODE  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_BLOCK   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_INODE   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_STACK_FULL = 2'd3;

    // Bits of the last bitmap word that lie beyond the last block read as occupied.
    function automatic logic [WORD_W-1:0] tail_mask(input int nb);
        logic [WORD_SHIFT-1:0] rem;
        logic [WORD_W-1:0]     m;
        rem = nb[WORD_SHIFT-1:0];
        m   = '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            if ((rem != '0) && (b >= int'(rem)))
            begin
                m[b] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

// ===== sv/bbia_req_if.sv =====
interface bbia_req_if #(
    parameter int NUM_BLOCKS = bbia_pkg::NUM_BLOCKS_DEF,
    parameter int NUM_INODES = bbia_pkg::NUM_INODES_DEF
) ();
    import bbia_pkg::*;

    localparam int BW = $clog2(NUM_BLOCKS);
    localparam int IW = $clog2(NUM_INODES);

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [BW-1:0]     block_num;
    logic [IW-1:0]     inode_id;

    modport source (output valid, output func, output block_num, output inode_id, input ready);
    modport sink   (input valid, input func, input block_num, input inode_id, output ready);

endinterface

// ===== sv/bbia_rsp_if.sv =====
interface bbia_rsp_if #(
    parameter int NUM_BLOCKS = bbia_pkg::NUM_BLOCKS_DEF,
    parameter int NUM_INODES = bbia_pkg::NUM_INODES_DEF
) ();
    import bbia_pkg::*;

    localparam int BW = $clog2(NUM_BLOCKS);
    localparam int FW = $clog2(NUM_BLOCKS + 1);
    localparam int IW = $clog2(NUM_INODES);

    logic                valid;
    logic                ready;
    logic [BW-1:0]       alloc_block;
    logic [IW-1:0]       alloc_inode;
    logic [STATUS_W-1:0] status;
    logic [FW-1:0]       free_blocks;
    logic [IW-1:0]       free_inodes;

    modport source (output valid, output alloc_block, output alloc_inode, output status,
                    output free_blocks, output free_inodes, input ready);
    modport sink   (input valid, input alloc_block, input alloc_inode, input status,
                    input free_blocks, input free_inodes, output ready);

endinterface

// ===== sv/block_bitmap_and_inode_stack_allocator_top.sv =====
// Block bitmap and free inode stack allocator.
// One request channel (req) carries func, block_num and inode_id; one response
// channel (rsp) returns alloc_block, alloc_inode, status and both free counts.
// Every accepted request produces exactly one response.
// The block works on one request at a time. Free and mark requests take one
// bitmap read and write back; inode pops take one stack read, and pushes write
// the stack as the request is accepted.
// Block allocation scans the bitmap memory one 32-bit word per cycle from
// word zero until it finds a word with a free bit.
// The next request is accepted in the cycle in which the previous response can
// be taken, so a new request is never accepted before the previous one is done.
// After reset the block loads the bitmap and inode stack memories; req.ready
// stays low during that pass.
// A finished response waits in an output register while the receiver stalls,
// and a new request is accepted meanwhile; its own response then waits until
// the register is free.
`include "block_bitmap_and_inode_stack_allocator_top_defines.svh"

module block_bitmap_and_inode_stack_allocator_top #(
    parameter int NUM_BLOCKS = bbia_pkg::NUM_BLOCKS_DEF,
    parameter int NUM_INODES = bbia_pkg::NUM_INODES_DEF
) (
    input logic         clk,
    input logic         rst_n,
    bbia_req_if.sink    req,
    bbia_rsp_if.source  rsp
);
    import bbia_pkg::*;

    localparam int BW        = $clog2(NUM_BLOCKS);
    localparam int FW        = $clog2(NUM_BLOCKS + 1);
    localparam int IW        = $clog2(NUM_INODES);
    localparam int DEPTH     = NUM_INODES - 1;
    localparam int SA        = $clog2(DEPTH);
    localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WA        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int INIT_N    = (NUM_WORDS > DEPTH) ? NUM_WORDS : DEPTH;
    localparam int CW        = $clog2(INIT_N);

    localparam logic [WORD_W-1:0] TAIL = tail_mask(NUM_BLOCKS);
    localparam logic [BW:0]       NB_C = (BW + 1)'(NUM_BLOCKS);

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_BREAD = 6'b000100,
        S_SCAN  = 6'b001000,
        S_IPOP  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]       init_cnt_reg, init_cnt_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [WA-1:0]       blk_word_reg, blk_word_next;
    logic [WORD_SHIFT-1:0] blk_pos_reg, blk_pos_next;
    logic                blk_ok_reg, blk_ok_next;
    logic [WA-1:0]       scan_reg, scan_next;
    logic [WA-1:0]       scan_d_reg, scan_d_next;
    logic                scan_v_reg, scan_v_next;
    logic [FW-1:0]       fb_cnt_reg, fb_cnt_next;
    logic [IW-1:0]       fi_cnt_reg, fi_cnt_next;
    logic [BW-1:0]       res_block_reg, res_block_next;
    logic [IW-1:0]       res_inode_reg, res_inode_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [BW-1:0]       out_block_reg, out_block_next;
    logic [IW-1:0]       out_inode_reg, out_inode_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [FW-1:0]       out_fb_reg, out_fb_next;
    logic [IW-1:0]       out_fi_reg, out_fi_next;

    logic              accept;
    logic [BW-1:0]     in_sh;
    logic [WA-1:0]     in_word;
    logic [WORD_SHIFT-1:0] in_pos;
    logic              in_ok;
    logic [WORD_W-1:0] free_mask;
    logic              has_free;
    logic [WORD_SHIFT-1:0] free_pos;
    logic [WORD_W-1:0] blk_bit;
    logic [IW-1:0]     fi_dec;
    logic              done_load;

    logic              bm_we;
    logic [WA-1:0]     bm_waddr;
    logic [WORD_W-1:0] bm_wdata;
    logic [WA-1:0]     bm_raddr;
    logic [WORD_W-1:0] bm_rdata;

    logic              sk_we;
    logic [SA-1:0]     sk_waddr;
    logic [IW-1:0]     sk_wdata;
    logic              sk_re;
    logic [SA-1:0]     sk_raddr;
    logic [IW-1:0]     sk_rdata;

    bbia_ram #(.WIDTH(WORD_W), .DEPTH(NUM_WORDS), .AW(WA)) u_bitmap (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .re    (1'b1),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    bbia_ram #(.WIDTH(IW), .DEPTH(DEPTH), .AW(SA)) u_stack (
        .clk   (clk),
        .we    (sk_we),
        .waddr (sk_waddr),
        .wdata (sk_wdata),
        .re    (sk_re),
        .raddr (sk_raddr),
        .rdata (sk_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    assign in_sh   = req.block_num >> WORD_SHIFT;
    assign in_word = in_sh[WA-1:0];
    assign in_pos  = WORD_SHIFT'(req.block_num);
    assign in_ok   = ({1'b0, req.block_num} < NB_C);

    assign free_mask = ~bm_rdata;
    assign has_free  = |free_mask;
    assign blk_bit   = WORD_W'(1) << blk_pos_reg;
    assign fi_dec    = fi_cnt_reg - IW'(1);
    assign done_load = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        free_pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (free_mask[i])
            begin
                free_pos = WORD_SHIFT'(i);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        init_cnt_next   = init_cnt_reg;
        func_next       = func_reg;
        blk_word_next   = blk_word_reg;
        blk_pos_next    = blk_pos_reg;
        blk_ok_next     = blk_ok_reg;
        scan_next       = scan_reg;
        scan_d_next     = scan_d_reg;
        scan_v_next     = scan_v_reg;
        fb_cnt_next     = fb_cnt_reg;
        fi_cnt_next     = fi_cnt_reg;
        res_block_next  = res_block_reg;
        res_inode_next  = res_inode_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_block_next  = out_block_reg;
        out_inode_next  = out_inode_reg;
        out_status_next = out_status_reg;
        out_fb_next     = out_fb_reg;
        out_fi_next     = out_fi_reg;

        bm_we    = 1'b0;
        bm_waddr = blk_word_reg;
        bm_wdata = bm_rdata;
        bm_raddr = scan_reg;
        sk_we    = 1'b0;
        sk_waddr = fi_cnt_reg[SA-1:0];
        sk_wdata = req.inode_id;
        sk_re    = 1'b0;
        sk_raddr = fi_dec[SA-1:0];

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                if (init_cnt_reg < NUM_WORDS)
                begin
                    bm_we    = 1'b1;
                    bm_waddr = init_cnt_reg[WA-1:0];
                    bm_wdata = (init_cnt_reg == CW'(NUM_WORDS - 1)) ? TAIL : '0;
                end
                if (init_cnt_reg < DEPTH)
                begin
                    sk_we    = 1'b1;
                    sk_waddr = init_cnt_reg[SA-1:0];
                    sk_wdata = IW'(DEPTH) - IW'(init_cnt_reg);
                end
                if (init_cnt_reg == CW'(INIT_N - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    init_cnt_next = init_cnt_reg + CW'(1);
                end
            end
            S_IDLE:
            begin
                bm_raddr = in_word;
                if (accept)
                begin
                    func_next       = req.func;
                    blk_word_next   = in_word;
                    blk_pos_next    = in_pos;
                    blk_ok_next     = in_ok;
                    res_block_next  = '0;
                    res_inode_next  = '0;
                    res_status_next = ST_OK;
                    case (req.func)
                        FN_ALLOC_BLOCK:
                        begin
                            if (fb_cnt_reg == '0)
                            begin
                                res_status_next = ST_NO_BLOCK;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                scan_next   = '0;
                                scan_v_next = 1'b0;
                                state_next  = S_SCAN;
                            end
                        end
                        FN_FREE_BLOCK, FN_MARK_BLOCK:
                        begin
                            state_next = S_BREAD;
                        end
                        FN_ALLOC_INODE:
                        begin
                            if (fi_cnt_reg == '0)
                            begin
                                res_status_next = ST_NO_INODE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                sk_re       = 1'b1;
                                fi_cnt_next = fi_dec;
                                state_next  = S_IPOP;
                            end
                        end
                        FN_FREE_INODE:
                        begin
                            if (fi_cnt_reg >= IW'(DEPTH))
                            begin
                                res_status_next = ST_STACK_FULL;
                            end
                            else
                            begin
                                sk_we       = 1'b1;
                                fi_cnt_next = fi_cnt_reg + IW'(1);
                            end
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_BREAD:
            begin
                if (blk_ok_reg)
                begin
                    if ((func_reg == FN_FREE_BLOCK) && bm_rdata[blk_pos_reg])
                    begin
                        bm_we       = 1'b1;
                        bm_wdata    = bm_rdata & ~blk_bit;
                        fb_cnt_next = fb_cnt_reg + FW'(1);
                    end
                    else if ((func_reg == FN_MARK_BLOCK) && !bm_rdata[blk_pos_reg])
                    begin
                        bm_we       = 1'b1;
                        bm_wdata    = bm_rdata | blk_bit;
                        fb_cnt_next = fb_cnt_reg - FW'(1);
                    end
                end
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                bm_raddr    = scan_reg;
                scan_next   = scan_reg + WA'(1);
                scan_d_next = scan_reg;
                scan_v_next = 1'b1;
                if (scan_v_reg && has_free)
                begin
                    bm_we          = 1'b1;
                    bm_waddr       = scan_d_reg;
                    bm_wdata       = bm_rdata | (WORD_W'(1) << free_pos);
                    fb_cnt_next    = fb_cnt_reg - FW'(1);
                    res_block_next = BW'({scan_d_reg, free_pos});
                    state_next     = S_DONE;
                end
            end
            S_IPOP:
            begin
                res_inode_next = sk_rdata;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_block_next  = res_block_reg;
                    out_inode_next  = res_inode_reg;
                    out_status_next = res_status_reg;
                    out_fb_next     = fb_cnt_reg;
                    out_fi_next     = fi_cnt_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_cnt_reg  <= '0;
            scan_reg      <= '0;
            scan_v_reg    <= 1'b0;
            fb_cnt_reg    <= FW'(NUM_BLOCKS);
            fi_cnt_reg    <= IW'(DEPTH);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_cnt_reg  <= init_cnt_next;
            scan_reg      <= scan_next;
            scan_v_reg    <= scan_v_next;
            fb_cnt_reg    <= fb_cnt_next;
            fi_cnt_reg    <= fi_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        blk_word_reg   <= blk_word_next;
        blk_pos_reg    <= blk_pos_next;
        blk_ok_reg     <= blk_ok_next;
        scan_d_reg     <= scan_d_next;
        res_block_reg  <= res_block_next;
        res_inode_reg  <= res_inode_next;
        res_status_reg <= res_status_next;
        out_block_reg  <= out_block_next;
        out_inode_reg  <= out_inode_next;
        out_status_reg <= out_status_next;
        out_fb_reg     <= out_fb_next;
        out_fi_reg     <= out_fi_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.alloc_block = out_block_reg;
    assign rsp.alloc_inode = out_inode_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.free_blocks = out_fb_reg;
    assign rsp.free_inodes = out_fi_reg;

    `BBIA_ASSERT_IMP(a_fb_bound, 1'b1, fb_cnt_reg <= FW'(NUM_BLOCKS))
    `BBIA_ASSERT_IMP(a_fi_bound, 1'b1, fi_cnt_reg <= IW'(DEPTH))
    `BBIA_ASSERT_IMP(a_scan_nonempty, state_reg == S_SCAN, fb_cnt_reg != '0)
    `BBIA_ASSERT_NXT(a_done_load, done_load, out_valid_reg && (state_reg == S_IDLE))

endmodule

// ===== sv/bbia_ram.sv =====
module bbia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== bench/testbench.sv =====
module testbench;
    import bbia_pkg::*;

    localparam int NB          = NUM_BLOCKS_DEF;
    localparam int NI          = NUM_INODES_DEF;
    localparam int BW          = $clog2(NB);
    localparam int FW          = $clog2(NB + 1);
    localparam int IW          = $clog2(NI);
    localparam int STACK_DEPTH = NI - 1;

    localparam logic [FUNC_W-1:0] FN_FIRST_UNUSED = FN_FREE_INODE + 1'b1;
    localparam logic [FUNC_W-1:0] FN_LAST_UNUSED  = '1;

    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 1040;
    localparam int TAIL_ITEMS    = 40;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 500000;

    typedef struct packed {
        logic [BW-1:0]       alloc_block;
        logic [IW-1:0]       alloc_inode;
        logic [STATUS_W-1:0] status;
        logic [FW-1:0]       free_blocks;
        logic [IW-1:0]       free_inodes;
    } alloc_result_t;

    class allocator_mirror;
        bit [NB-1:0]   block_used;
        int unsigned   blocks_free;
        logic [IW-1:0] inode_slots [STACK_DEPTH];
        int unsigned   inodes_free;
        alloc_result_t pending_responses [$];
        int            errors;

        function new();
            block_used  = '0;
            blocks_free = NB;
            for (int i = 0; i < STACK_DEPTH; i++)
            begin
                inode_slots[i] = IW'(STACK_DEPTH - i);
            end
            inodes_free = STACK_DEPTH;
            errors      = 0;
        endfunction

        function int pending();
            return pending_responses.size();
        endfunction

        // Random block whose occupancy matches the request, or any block if none does.
        function logic [BW-1:0] pick_block(bit occupied);
            int start;
            int idx;
            start = $urandom_range(0, NB - 1);
            for (int k = 0; k < NB; k++)
            begin
                idx = (start + k) % NB;
                if (block_used[idx] == occupied)
                begin
                    return idx[BW-1:0];
                end
            end
            return start[BW-1:0];
        endfunction

        function void apply_request(logic [FUNC_W-1:0] fn, logic [BW-1:0] blk,
                                    logic [IW-1:0] ino);
            alloc_result_t r;
            r        = '0;
            r.status = ST_OK;
            case (fn)
                FN_ALLOC_BLOCK:
                begin
                    r.status = ST_NO_BLOCK;
                    if (blocks_free != 0)
                    begin
                        for (int i = 0; i < NB; i++)
                        begin
                            if (!block_used[i])
                            begin
                                block_used[i] = 1'b1;
                                blocks_free--;
                                r.alloc_block = i[BW-1:0];
                                r.status      = ST_OK;
                                break;
                            end
                        end
                    end
                end
                FN_FREE_BLOCK:
                begin
                    if (int'(blk) < NB && block_used[blk])
                    begin
                        block_used[blk] = 1'b0;
                        blocks_free++;
                    end
                end
                FN_MARK_BLOCK:
                begin
                    if (int'(blk) < NB && !block_used[blk])
                    begin
                        block_used[blk] = 1'b1;
                        blocks_free--;
                    end
                end
                FN_ALLOC_INODE:
                begin
                    if (inodes_free == 0)
                    begin
                        r.status = ST_NO_INODE;
                    end
                    else
                    begin
                        inodes_free--;
                        r.alloc_inode = inode_slots[inodes_free];
                    end
                end
                FN_FREE_INODE:
                begin
                    if (inodes_free >= STACK_DEPTH)
                    begin
                        r.status = ST_STACK_FULL;
                    end
                    else
                    begin
                        inode_slots[inodes_free] = ino;
                        inodes_free++;
                    end
                end
                default:
                begin
                end
            endcase
            r.free_blocks = FW'(blocks_free);
            r.free_inodes = IW'(inodes_free);
            pending_responses.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_response(alloc_result_t got);
            alloc_result_t want;
            if (pending_responses.size() == 0)
            begin
                $error("response arrived with no request outstanding");
                errors++;
                return;
            end
            want = pending_responses.pop_front();
            compare_field("alloc_block", 32'(want.alloc_block), 32'(got.alloc_block));
            compare_field("alloc_inode", 32'(want.alloc_inode), 32'(got.alloc_inode));
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("free_blocks", 32'(want.free_blocks), 32'(got.free_blocks));
            compare_field("free_inodes", 32'(want.free_inodes), 32'(got.free_inodes));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    bbia_req_if #(.NUM_BLOCKS(NB), .NUM_INODES(NI)) req_ch ();
    bbia_rsp_if #(.NUM_BLOCKS(NB), .NUM_INODES(NI)) rsp_ch ();

    block_bitmap_and_inode_stack_allocator_top #(
        .NUM_BLOCKS(NB),
        .NUM_INODES(NI)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    allocator_mirror mirror = new();

    int send_idle        = 0;
    int sink_idle        = 0;
    int receiver_hold    = 0;
    int cycle_count      = 0;
    bit pop_heavy        = 1'b1;
    int block_empty_hits = 0;
    int inode_empty_hits = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("block_bitmap_and_inode_stack_allocator_top: mismatch");
            $finish;
        end
    end

    function automatic bit idle_roll(int level);
        case (level)
            1: return $urandom_range(0, 7) == 0;
            2: return $urandom_range(0, 2) == 0;
            default: return 1'b0;
        endcase
    endfunction

    task automatic send_request(logic [FUNC_W-1:0] fn, logic [BW-1:0] blk, logic [IW-1:0] ino);
        int gap;
        if (idle_roll(send_idle))
        begin
            gap = $urandom_range(1, 11);
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid     <= 1'b1;
        req_ch.func      <= fn;
        req_ch.block_num <= blk;
        req_ch.inode_id  <= ino;
        do
            @(posedge clk);
        while (!req_ch.ready);
        mirror.apply_request(fn, blk, ino);
    endtask

    // Inode requests walk the stack between empty and full; block requests drain
    // the bitmap first and then mix frees, allocations and marks.
    task automatic random_request();
        int               roll;
        int               sub;
        bit               pop;
        logic [FUNC_W-1:0] fn;
        logic [BW-1:0]    blk;
        logic [IW-1:0]    ino;
        roll = $urandom_range(0, 99);
        blk  = BW'($urandom_range(0, NB - 1));
        ino  = IW'($urandom_range(0, NI - 1));
        if (roll < 1)
        begin
            fn = FUNC_W'($urandom_range(FN_FIRST_UNUSED, FN_LAST_UNUSED));
        end
        else if (roll < 15)
        begin
            pop = pop_heavy ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 9) == 0);
            if (pop)
            begin
                fn = FN_ALLOC_INODE;
                if (mirror.inodes_free == 0)
                begin
                    pop_heavy = 1'b0;
                    inode_empty_hits++;
                end
            end
            else
            begin
                fn = FN_FREE_INODE;
                if (mirror.inodes_free >= STACK_DEPTH)
                begin
                    pop_heavy = 1'b1;
                end
            end
        end
        else
        begin
            sub = $urandom_range(0, 99);
            if (block_empty_hits == 0)
            begin
                if (sub < 75)
                begin
                    fn = FN_ALLOC_BLOCK;
                end
                else
                begin
                    fn  = FN_MARK_BLOCK;
                    blk = mirror.pick_block(1'b0);
                end
            end
            else if (sub < 35)
            begin
                fn = FN_ALLOC_BLOCK;
            end
            else if (sub < 70)
            begin
                fn  = FN_FREE_BLOCK;
                blk = mirror.pick_block(1'b1);
            end
            else if (sub < 80)
            begin
                fn = FN_FREE_BLOCK;
            end
            else
            begin
                fn = FN_MARK_BLOCK;
            end
            if (fn == FN_ALLOC_BLOCK && mirror.blocks_free == 0)
            begin
                block_empty_hits++;
            end
        end
        send_request(fn, blk, ino);
    endtask

    initial
    begin
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (receiver_hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                receiver_hold--;
            end
            else if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_roll(sink_idle))
            begin
                rsp_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 11) - 1;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        alloc_result_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.alloc_block = rsp_ch.alloc_block;
            got.alloc_inode = rsp_ch.alloc_inode;
            got.status      = rsp_ch.status;
            got.free_blocks = rsp_ch.free_blocks;
            got.free_inodes = rsp_ch.free_inodes;
            mirror.check_response(got);
        end
    end

    initial
    begin
        int n;
        int after_drain;
        n                = 0;
        after_drain      = 0;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.func      = FN_ALLOC_BLOCK;
        req_ch.block_num = '0;
        req_ch.inode_id  = '0;
        send_idle        = $urandom_range(0, 2);
        sink_idle        = $urandom_range(0, 2);
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // The inode stack starts full, so the first push is refused.
        send_request(FN_FREE_INODE, '0, IW'(5));
        send_request(FN_ALLOC_BLOCK, '0, '0);
        send_request(FN_ALLOC_BLOCK, '1, '1);
        send_request(FN_FREE_BLOCK, '0, '0);
        send_request(FN_FREE_BLOCK, '0, '0);
        send_request(FN_MARK_BLOCK, '1, '0);
        send_request(FN_MARK_BLOCK, '1, '0);
        send_request(FN_ALLOC_BLOCK, '0, '0);
        send_request(FN_FREE_BLOCK, '1, '1);
        send_request(FN_MARK_BLOCK, BW'(NB / 2), '0);
        send_request(FN_FREE_BLOCK, BW'(NB / 2), '0);
        send_request(FN_ALLOC_INODE, '1, '1);
        send_request(FN_FREE_INODE, '0, '0);
        send_request(FN_ALLOC_INODE, '0, '0);
        send_request(FN_FREE_INODE, '0, '1);
        send_request(FN_FREE_INODE, '0, '1);
        send_request(FN_ALLOC_INODE, '0, '0);
        for (int f = FN_FIRST_UNUSED; f <= FN_LAST_UNUSED; f++)
        begin
            send_request(FUNC_W'(f), BW'($urandom_range(0, NB - 1)),
                         IW'($urandom_range(0, NI - 1)));
        end
        send_request(FN_LAST_UNUSED, '1, '1);
        send_request(FN_ALLOC_BLOCK, '0, '0);

        while (!(n >= RANDOM_ITEMS && block_empty_hits > 0 && inode_empty_hits > 0
                 && after_drain >= 20))
        begin
            if (n % 100 == 0)
            begin
                send_idle = $urandom_range(0, 2);
                sink_idle = $urandom_range(0, 2);
            end
            if (n == 150)
            begin
                receiver_hold = LONG_HOLD;
            end
            random_request();
            if (block_empty_hits > 0)
            begin
                after_drain++;
            end
            n++;
        end

        send_idle = 0;
        sink_idle = 0;
        repeat (TAIL_ITEMS) random_request();
        @(negedge clk);
        req_ch.valid <= 1'b0;

        while (mirror.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mirror.errors == 0)
        begin
            $display("block_bitmap_and_inode_stack_allocator_top: match");
        end
        else
        begin
            $display("block_bitmap_and_inode_stack_allocator_top: mismatch");
        end
        $finish;
    end

endmodule
